### rtl/cpb_pkg.sv
// Shared types, codes and default constants for the color presence bitmap.
package cpb_pkg;

    // Default configuration
    localparam int CHANNEL_BITS_DEF = 6;
    localparam int MAP_BYTES_DEF    = 32768;

    // Fixed field widths
    localparam int CHAN_W        = 6;
    localparam int CHAN_EXT_W    = 8;
    localparam int COUNT_W       = 19;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Kind of result loaded into the output register
    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_FOUND,
        RES_DONE
    } t_kind;

    // Controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_CLEAR,
        S_REPLY
    } t_state;

    typedef struct packed {
        t_op                opcode;
        logic [CHAN_W-1:0]  pixel_red;
        logic [CHAN_W-1:0]  pixel_green;
        logic [CHAN_W-1:0]  pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] distinct_count;
        logic [CHAN_W-1:0]  found_red;
        logic [CHAN_W-1:0]  found_green;
        logic [CHAN_W-1:0]  found_blue;
        logic               color_found;
        logic               scan_done;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic  rd_pixel;
        logic  rd_cursor;
        logic  scan_step;
        logic  scan_found;
        logic  scan_end;
        logic  mark_commit;
        logic  clear_regs;
        logic  clr_write;
        logic  load_out;
        t_kind kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic at_end;
        logic scan_hit;
        logic scan_last;
        logic clr_last;
    } t_status;

endpackage

### rtl/cpb_ctrl.sv
// Controller state machine: sequences mark, scan, clear and result loading.
module cpb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cpb_pkg::t_op     i_opcode,
    input  cpb_pkg::t_status i_status,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output cpb_pkg::t_cmd    o_cmd
);

    cpb_pkg::t_state r_state, n_state;
    cpb_pkg::t_kind  r_kind, n_kind;
    logic            r_out_valid, n_out_valid;
    logic            slot_free;

    // Output register can take a result this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            cpb_pkg::S_INIT: begin
                if (i_status.clr_last) begin
                    n_state = cpb_pkg::S_IDLE;
                end
            end
            cpb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_opcode)
                        cpb_pkg::OP_CLEAR: n_state = cpb_pkg::S_CLEAR;
                        cpb_pkg::OP_MARK:  n_state = cpb_pkg::S_MARK;
                        cpb_pkg::OP_NEXT: begin
                            if (i_status.at_end) begin
                                n_state = cpb_pkg::S_REPLY;
                                n_kind  = cpb_pkg::RES_DONE;
                            end else begin
                                n_state = cpb_pkg::S_SCAN;
                            end
                        end
                        cpb_pkg::OP_NOP: begin
                            n_state = cpb_pkg::S_REPLY;
                            n_kind  = cpb_pkg::RES_PLAIN;
                        end
                        default: n_state = cpb_pkg::S_IDLE;
                    endcase
                end
            end
            cpb_pkg::S_MARK: begin
                if (slot_free) begin
                    n_state = cpb_pkg::S_IDLE;
                end
            end
            cpb_pkg::S_SCAN: begin
                if ((i_status.scan_hit || i_status.scan_last) && slot_free) begin
                    n_state = cpb_pkg::S_IDLE;
                end
            end
            cpb_pkg::S_CLEAR: begin
                if (i_status.clr_last && slot_free) begin
                    n_state = cpb_pkg::S_IDLE;
                end
            end
            cpb_pkg::S_REPLY: begin
                if (slot_free) begin
                    n_state = cpb_pkg::S_IDLE;
                end
            end
            default: n_state = cpb_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = cpb_pkg::RES_PLAIN;
        o_in_ready = 1'b0;
        unique case (r_state)
            cpb_pkg::S_INIT: begin
                o_cmd.clr_write = 1'b1;
            end
            cpb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        cpb_pkg::OP_CLEAR: o_cmd.clear_regs = 1'b1;
                        cpb_pkg::OP_MARK:  o_cmd.rd_pixel   = 1'b1;
                        cpb_pkg::OP_NEXT:  o_cmd.rd_cursor  = !i_status.at_end;
                        cpb_pkg::OP_NOP:   o_cmd.rd_cursor  = 1'b0;
                        default:           o_cmd.rd_cursor  = 1'b0;
                    endcase
                end
            end
            cpb_pkg::S_MARK: begin
                if (slot_free) begin
                    o_cmd.mark_commit = 1'b1;
                    o_cmd.load_out    = 1'b1;
                end
            end
            cpb_pkg::S_SCAN: begin
                if (i_status.scan_hit) begin
                    if (slot_free) begin
                        o_cmd.scan_found = 1'b1;
                        o_cmd.load_out   = 1'b1;
                        o_cmd.kind       = cpb_pkg::RES_FOUND;
                    end
                end else if (i_status.scan_last) begin
                    if (slot_free) begin
                        o_cmd.scan_end = 1'b1;
                        o_cmd.load_out = 1'b1;
                        o_cmd.kind     = cpb_pkg::RES_DONE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            cpb_pkg::S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.load_out  = i_status.clr_last && slot_free;
            end
            cpb_pkg::S_REPLY: begin
                o_cmd.load_out = slot_free;
                o_cmd.kind     = r_kind;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpb_pkg::S_INIT;
            r_kind      <= cpb_pkg::RES_PLAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/cpb_datapath.sv
// Datapath: presence map memory, count, scan cursor, sweep counter, result register.
module cpb_datapath #(
    parameter int CHANNEL_BITS = cpb_pkg::CHANNEL_BITS_DEF,
    parameter int MAP_BYTES    = cpb_pkg::MAP_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpb_pkg::t_in_item  i_in_item,
    input  cpb_pkg::t_cmd      i_cmd,
    output cpb_pkg::t_status   o_status,
    output cpb_pkg::t_out_item o_out_item
);

    localparam int IDX_W       = 3 * CHANNEL_BITS;
    localparam int COLOR_TOTAL = 1 << IDX_W;
    localparam int MAP_BITS    = MAP_BYTES * 8;
    localparam int SCAN_LIMIT  = (COLOR_TOTAL < MAP_BITS) ? COLOR_TOTAL : MAP_BITS;
    localparam int MEM_DEPTH   = SCAN_LIMIT / 8;
    localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CUR_W       = $clog2(SCAN_LIMIT + 1);
    localparam int BYTE_W      = CUR_W - 3;
    localparam int CW          = cpb_pkg::COUNT_W;
    localparam int EW          = cpb_pkg::CHAN_EXT_W;

    // Map storage
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        r_rdata;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    logic [CW-1:0]     r_count, n_count;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_pix_addr;
    logic [2:0]        r_pix_bit;
    logic              r_pix_in;
    cpb_pkg::t_out_item r_out, n_out;

    logic [EW-1:0]     red8, green8, blue8;
    logic [IDX_W-1:0]  pix_idx;
    logic              pix_in;
    logic [AW-1:0]     pix_addr;
    logic              mark_new;

    logic [BYTE_W-1:0] cur_byte, next_byte;
    logic [2:0]        cur_off;
    logic              scan_hit;
    logic [2:0]        hit_pos;
    logic [CUR_W-1:0]  hit_cursor;
    logic [IDX_W-1:0]  hit_idx;
    logic [EW-1:0]     hit_red, hit_green, hit_blue;
    logic              clr_last;

    // Pixel color index, each channel masked to the channel width
    always_comb begin
        red8     = EW'(i_in_item.pixel_red);
        green8   = EW'(i_in_item.pixel_green);
        blue8    = EW'(i_in_item.pixel_blue);
        pix_idx  = {red8[CHANNEL_BITS-1:0], green8[CHANNEL_BITS-1:0],
                    blue8[CHANNEL_BITS-1:0]};
        pix_in   = ({1'b0, pix_idx} < (IDX_W + 1)'(SCAN_LIMIT));
        pix_addr = pix_in ? AW'(pix_idx >> 3) : '0;
    end

    // Mark: new only when in range and the bit was clear
    assign mark_new = r_pix_in && !r_rdata[3'd7 - r_pix_bit];

    // Scan: first set bit at or after the cursor within the fetched byte
    assign cur_byte  = r_cursor[CUR_W-1:3];
    assign cur_off   = r_cursor[2:0];
    assign next_byte = cur_byte + 1'b1;

    always_comb begin
        scan_hit = 1'b0;
        hit_pos  = 3'd0;
        for (int p = 7; p >= 0; p--) begin
            if ((3'(p) >= cur_off) && r_rdata[7 - p]) begin
                scan_hit = 1'b1;
                hit_pos  = 3'(p);
            end
        end
    end

    assign hit_cursor = {cur_byte, hit_pos};
    assign hit_idx    = IDX_W'(hit_cursor);
    assign hit_red    = EW'(hit_idx[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
    assign hit_green  = EW'(hit_idx[2*CHANNEL_BITS-1:CHANNEL_BITS]);
    assign hit_blue   = EW'(hit_idx[CHANNEL_BITS-1:0]);

    assign clr_last = (r_clr_addr == AW'(MEM_DEPTH - 1));

    always_comb begin
        o_status.at_end    = (r_cursor == CUR_W'(SCAN_LIMIT));
        o_status.scan_hit  = scan_hit;
        o_status.scan_last = (cur_byte == BYTE_W'(MEM_DEPTH - 1));
        o_status.clr_last  = clr_last;
    end

    // Memory read and write ports
    always_comb begin
        rd_en = i_cmd.rd_pixel || i_cmd.rd_cursor || i_cmd.scan_step;
        priority if (i_cmd.rd_pixel) begin
            rd_addr = pix_addr;
        end else if (i_cmd.rd_cursor) begin
            rd_addr = AW'(cur_byte);
        end else begin
            rd_addr = AW'(next_byte);
        end
        wr_en = i_cmd.clr_write || (i_cmd.mark_commit && mark_new);
        if (i_cmd.clr_write) begin
            wr_addr = r_clr_addr;
            wr_data = 8'h00;
        end else begin
            wr_addr = r_pix_addr;
            wr_data = r_rdata | (8'h80 >> r_pix_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Count and cursor updates
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear_regs) begin
            n_count = '0;
        end else if (i_cmd.mark_commit && mark_new) begin
            n_count = r_count + 1'b1;
        end

        n_cursor = r_cursor;
        priority if (i_cmd.clear_regs) begin
            n_cursor = '0;
        end else if (i_cmd.scan_found) begin
            n_cursor = hit_cursor + 1'b1;
        end else if (i_cmd.scan_step) begin
            n_cursor = {next_byte, 3'b000};
        end else if (i_cmd.scan_end) begin
            n_cursor = CUR_W'(SCAN_LIMIT);
        end
    end

    // Build the result item
    always_comb begin
        n_out                = '0;
        n_out.distinct_count = n_count;
        unique case (i_cmd.kind)
            cpb_pkg::RES_FOUND: begin
                n_out.found_red   = hit_red[cpb_pkg::CHAN_W-1:0];
                n_out.found_green = hit_green[cpb_pkg::CHAN_W-1:0];
                n_out.found_blue  = hit_blue[cpb_pkg::CHAN_W-1:0];
                n_out.color_found = 1'b1;
            end
            cpb_pkg::RES_DONE:  n_out.scan_done   = 1'b1;
            cpb_pkg::RES_PLAIN: n_out.color_found = 1'b0;
            default:            n_out.scan_done   = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cursor   <= '0;
            r_clr_addr <= '0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (i_cmd.clear_regs) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_write && !clr_last) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pixel) begin
            r_pix_addr <= pix_addr;
            r_pix_bit  <= pix_idx[2:0];
            r_pix_in   <= pix_in;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

### rtl/color_presence_bitmap.sv
// Top level of the color presence bitmap: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one item at a
// time: clear, mark a pixel color, report the next present color, or no-op.
// Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
// result per item, carrying the distinct color count after that item.
// Per item: a mark reads its map byte on acceptance, then sets its bit as
// its result is loaded; a next item reads the cursor's byte, then walks on
// byte by byte until it finds a set bit or passes the last byte; a clear
// zeroes the map byte by byte. The block finishes one item before it takes
// the next. The map memory is read or written at most one byte per cycle,
// which sets the scan and clear times; by default the map holds 32768 bytes.
// After reset the block runs a clearing pass over every map byte with
// o_in_ready low before it takes its first item.
// A finished result sits in an output register; a new item is accepted
// while it waits. If the receiver stalls, the next item's work finishes up
// to its final step and then holds until the output register frees.
module color_presence_bitmap #(
    parameter int CHANNEL_BITS = cpb_pkg::CHANNEL_BITS_DEF,
    parameter int MAP_BYTES    = cpb_pkg::MAP_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpb_pkg::t_out_item o_out_item
);

    cpb_pkg::t_cmd    cmd;
    cpb_pkg::t_status status;

    cpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_item.opcode),
        .i_status    (status),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cpb_datapath #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .MAP_BYTES    (MAP_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

### rtl/cpb_checker.sv
// Port-level checker for the color presence bitmap, bound to the top level.
module cpb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cpb_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cpb_pkg::t_out_item o_out_item
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // One item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // Found and done never together
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.color_found && o_out_item.scan_done))
        else $error("found and done both set");

    // Color fields are zero unless a color was found
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.color_found |->
            o_out_item.found_red == '0 && o_out_item.found_green == '0 &&
            o_out_item.found_blue == '0)
        else $error("color fields set without a found color");

endmodule

bind color_presence_bitmap cpb_checker u_cpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

### sim/color_presence_bitmap_checker.sv
// Channel monitor for the color presence bitmap: models the map and checks every reply.
module color_presence_bitmap_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  cpb_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  cpb_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_owed_count
);

    localparam int COLOR_SPAN = 1 << (3 * cpb_pkg::CHANNEL_BITS_DEF);
    localparam int MAP_SPAN   = cpb_pkg::MAP_BYTES_DEF * 8;
    localparam int SCAN_END   = (COLOR_SPAN < MAP_SPAN) ? COLOR_SPAN : MAP_SPAN;

    // Model of the map, the distinct count and the scan position
    bit                          color_seen [SCAN_END];
    logic [cpb_pkg::COUNT_W-1:0] seen_count = '0;
    int unsigned                 scan_pos   = 0;

    // Replies owed by the block, oldest first
    cpb_pkg::t_out_item          owed_replies [$];
    int                          fail_total = 0;

    function automatic void forget_colors();
        foreach (color_seen[i]) color_seen[i] = 1'b0;
        seen_count = '0;
        scan_pos   = 0;
    endfunction

    // Apply one item to the model and return the reply it produces
    function automatic cpb_pkg::t_out_item map_reply(cpb_pkg::t_in_item item);
        cpb_pkg::t_out_item reply;
        int unsigned        idx;
        reply = '0;
        case (item.opcode)
            cpb_pkg::OP_CLEAR: begin
                forget_colors();
            end
            cpb_pkg::OP_MARK: begin
                idx = 32'({item.pixel_red, item.pixel_green, item.pixel_blue});
                // count a color only the first time its bit is set
                if (idx < SCAN_END && !color_seen[idx]) begin
                    color_seen[idx] = 1'b1;
                    seen_count      = seen_count + 1'b1;
                end
            end
            cpb_pkg::OP_NEXT: begin
                idx = scan_pos;
                while (idx < SCAN_END && !color_seen[idx]) idx++;
                if (idx < SCAN_END) begin
                    {reply.found_red, reply.found_green, reply.found_blue} =
                        idx[3*cpb_pkg::CHAN_W-1:0];
                    reply.color_found = 1'b1;
                    scan_pos          = idx + 1;
                end else begin
                    // park at the end until the next clear
                    reply.scan_done = 1'b1;
                    scan_pos        = SCAN_END;
                end
            end
            default: ;
        endcase
        reply.distinct_count = seen_count;
        return reply;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // Compare finished replies, then log newly accepted items
    always @(posedge i_clk) begin
        cpb_pkg::t_out_item want;
        if (!i_rst_n) begin
            owed_replies.delete();
            forget_colors();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_replies.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected reply, expected none, actual %h",
                             $time, i_out_item);
                end else begin
                    want = owed_replies.pop_front();
                    flag_field("distinct_count", want.distinct_count,
                               i_out_item.distinct_count);
                    flag_field("found_red", want.found_red, i_out_item.found_red);
                    flag_field("found_green", want.found_green, i_out_item.found_green);
                    flag_field("found_blue", want.found_blue, i_out_item.found_blue);
                    flag_field("color_found", want.color_found, i_out_item.color_found);
                    flag_field("scan_done", want.scan_done, i_out_item.scan_done);
                end
            end
            if (i_in_valid && i_in_ready) owed_replies.push_back(map_reply(i_in_item));
        end
        o_owed_count <= owed_replies.size();
        o_fail_count <= fail_total;
    end

endmodule

### sim/color_presence_bitmap_test.sv
// Testbench top for the color presence bitmap: stimulus, stalls and verdict.
module color_presence_bitmap_test;

    localparam int CHAN_W           = cpb_pkg::CHAN_W;
    localparam int RANDOM_ITEMS     = 1825;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 80_000;
    localparam int CYCLE_LIMIT      = 10_000_000;
    localparam int DRAIN_CYCLES     = 64;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    cpb_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cpb_pkg::t_out_item out_item;

    int        fail_count;
    int        owed_count;
    int        cycle_count    = 0;
    int        results_seen   = 0;
    int        ready_left     = 0;
    bit        long_hold_done = 1'b0;
    bit        steady_sender  = 1'b0;

    color_presence_bitmap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    color_presence_bitmap_checker map_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_owed_count (owed_count)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item after an optional idle gap, hold it until accepted
    task automatic offer(input cpb_pkg::t_op op, input logic [CHAN_W-1:0] red,
                         input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        int gap;
        gap = steady_sender ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {op, red, green, blue};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Receiver: random stalls and open runs, one long hold-off to back up the block
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            ready_left <= 0;
        end else begin
            if (out_valid && out_ready) results_seen <= results_seen + 1;
            if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done <= 1'b1;
                out_ready      <= 1'b0;
                ready_left     <= LONG_HOLD_CYCLES;
            end else if (ready_left > 0) begin
                ready_left <= ready_left - 1;
            end else if ($urandom_range(0, 19) == 0) begin
                out_ready  <= 1'b1;
                ready_left <= $urandom_range(100, 300);
            end else begin
                out_ready  <= ($urandom_range(0, 1) == 1);
                ready_left <= gap_len();
            end
        end
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int                  sent;
        int                  epoch_left;
        int                  burst;
        int                  pool_size;
        bit                  dense;
        logic [3*CHAN_W-1:0] base;
        logic [3*CHAN_W-1:0] color;
        logic [3*CHAN_W-1:0] pool [$];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Scan an empty map, then stay done
        offer(cpb_pkg::OP_NEXT, 6'd5, 6'd9, 6'd17);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NOP, 6'h3f, 6'h3f, 6'h3f);
        // Start over so the marks below sit ahead of the cursor
        offer(cpb_pkg::OP_CLEAR, 6'd0, 6'd0, 6'd0);
        // Mark the corners, a repeat, and neighbors within one map byte
        offer(cpb_pkg::OP_MARK, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_MARK, 6'h3f, 6'h3f, 6'h3f);
        offer(cpb_pkg::OP_MARK, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_MARK, 6'd0, 6'h3f, 6'd0);
        offer(cpb_pkg::OP_MARK, 6'h3f, 6'd0, 6'h3f);
        offer(cpb_pkg::OP_MARK, 6'd21, 6'd42, 6'd21);
        offer(cpb_pkg::OP_MARK, 6'd0, 6'd0, 6'd1);
        offer(cpb_pkg::OP_MARK, 6'd0, 6'd0, 6'd7);
        // Walk them in index order; a color marked behind the cursor stays hidden
        offer(cpb_pkg::OP_NEXT, 6'h3f, 6'h3f, 6'h3f);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_MARK, 6'd0, 6'd0, 6'd2);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NOP, 6'd0, 6'd0, 6'd0);
        // Clear, then find the last color after a full walk
        offer(cpb_pkg::OP_CLEAR, 6'd42, 6'd21, 6'd42);
        offer(cpb_pkg::OP_MARK, 6'h3f, 6'h3f, 6'h3f);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);
        offer(cpb_pkg::OP_NEXT, 6'd0, 6'd0, 6'd0);

        // Random epochs: a clear, then bursts of marks followed by scans
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            offer(cpb_pkg::OP_CLEAR, 6'($urandom), 6'($urandom), 6'($urandom));
            sent++;
            steady_sender = ($urandom_range(0, 3) == 0);
            pool.delete();
            dense     = ($urandom_range(0, 1) == 1);
            base      = 18'($urandom);
            pool_size = $urandom_range(1, 24);
            repeat (pool_size)
                pool.push_back(dense ? base + 18'($urandom_range(0, 31)) : 18'($urandom));
            epoch_left = $urandom_range(150, 260);
            while (epoch_left > 0 && sent < RANDOM_ITEMS) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    case ($urandom_range(0, 9))
                        0: color = {(($urandom_range(0, 1) == 1) ? 6'h3f : 6'h00),
                                    (($urandom_range(0, 1) == 1) ? 6'h3f : 6'h00),
                                    (($urandom_range(0, 1) == 1) ? 6'h3f : 6'h00)};
                        1, 2: color = 18'($urandom);
                        default: color = pool[$urandom_range(0, pool.size() - 1)];
                    endcase
                    offer(cpb_pkg::OP_MARK, color[17:12], color[11:6], color[5:0]);
                end
                sent       += burst;
                epoch_left -= burst;
                burst = $urandom_range(1, 6);
                repeat (burst)
                    offer(cpb_pkg::OP_NEXT, 6'($urandom), 6'($urandom), 6'($urandom));
                sent       += burst;
                epoch_left -= burst;
                // drop in a stray no-op now and then
                if ($urandom_range(0, 4) == 0) begin
                    offer(cpb_pkg::OP_NOP, 6'($urandom), 6'($urandom), 6'($urandom));
                    sent++;
                    epoch_left--;
                end
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding replies, then watch for strays
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/cpb_pkg.sv
rtl/cpb_ctrl.sv
rtl/cpb_datapath.sv
rtl/color_presence_bitmap.sv
rtl/cpb_checker.sv
sim/color_presence_bitmap_checker.sv
sim/color_presence_bitmap_test.sv
